// File: design/local_interrupt_priority_unit_top_defines.svh
// Assertion helpers for the local interrupt priority unit
`ifndef LOCAL_INTERRUPT_PRIORITY_UNIT_TOP_DEFINES_SVH
`define LOCAL_INTERRUPT_PRIORITY_UNIT_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define LIPU_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define LIPU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lipu_pkg.sv
package lipu_pkg;

    localparam int NUM_VECTORS = 256;
    localparam int VIDX_W      = $clog2(NUM_VECTORS);
    localparam int TREE_SIZE   = 1 << VIDX_W;
    localparam int VEC_W       = 8;
    localparam int PRIO_W      = 8;
    localparam int FUNC_W      = 2;

    localparam logic [PRIO_W-1:0] CLASS_MASK = 8'hF0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_POST    = 2'd0,
        FUNC_ACK     = 2'd1,
        FUNC_EOI     = 2'd2,
        FUNC_SET_TPR = 2'd3
    } func_t;

    typedef logic [NUM_VECTORS-1:0] vec_map_t;

    typedef struct packed {
        func_t             func;
        logic [VEC_W-1:0]  vector;
        logic              level_trigger;
        logic [PRIO_W-1:0] task_priority;
    } lipu_req_t;

    typedef struct packed {
        logic             accepted;
        logic             delivered_valid;
        logic [VEC_W-1:0] delivered_vector;
        logic             retired_valid;
        logic             level_notify;
        logic [VEC_W-1:0] retired_vector;
    } lipu_exec_t;

    typedef struct packed {
        logic [PRIO_W-1:0] processor_priority;
        logic              deliverable_valid;
        logic [VEC_W-1:0]  deliverable_vector;
    } lipu_status_t;

    typedef struct packed {
        lipu_exec_t   exec;
        lipu_status_t status;
    } lipu_rsp_t;

    // processor priority from task priority and highest in-service vector
    function automatic logic [PRIO_W-1:0] calc_ppr(input logic [PRIO_W-1:0] tpr,
                                                  input logic [VEC_W-1:0]  isrv);
        logic [PRIO_W-1:0] isr_class;
        isr_class = isrv & CLASS_MASK;
        if ((tpr & CLASS_MASK) >= isr_class)
            return tpr;
        else
            return isr_class;
    endfunction

    function automatic logic is_deliverable(input logic              enabled,
                                            input logic              any,
                                            input logic [VEC_W-1:0]  top,
                                            input logic [PRIO_W-1:0] ppr);
        return enabled && any && ((top & CLASS_MASK) > ppr);
    endfunction

endpackage

// File: design/lipu_if.sv
interface lipu_req_if;
    logic                       valid;
    logic                       ready;
    logic [lipu_pkg::FUNC_W-1:0] func;
    logic [lipu_pkg::VEC_W-1:0]  vector;
    logic                       level_trigger;
    logic [lipu_pkg::PRIO_W-1:0] task_priority;

    modport source (output valid, func, vector, level_trigger, task_priority, input ready);
    modport sink   (input valid, func, vector, level_trigger, task_priority, output ready);
endinterface

interface lipu_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic                       delivered_valid;
    logic [lipu_pkg::VEC_W-1:0]  delivered_vector;
    logic                       retired_valid;
    logic                       level_notify;
    logic [lipu_pkg::VEC_W-1:0]  retired_vector;
    logic [lipu_pkg::PRIO_W-1:0] processor_priority;
    logic                       deliverable_valid;
    logic [lipu_pkg::VEC_W-1:0]  deliverable_vector;

    modport source (output valid, accepted, delivered_valid, delivered_vector, retired_valid,
                    level_notify, retired_vector, processor_priority, deliverable_valid,
                    deliverable_vector, input ready);
    modport sink   (input valid, accepted, delivered_valid, delivered_vector, retired_valid,
                    level_notify, retired_vector, processor_priority, deliverable_valid,
                    deliverable_vector, output ready);
endinterface

interface lipu_cfg_if;
    logic valid;
    logic ready;
    logic unit_enabled;

    modport source (output valid, unit_enabled, input ready);
    modport sink   (input valid, unit_enabled, output ready);
endinterface

// File: design/lipu_prio_enc.sv
module lipu_prio_enc (
    input  lipu_pkg::vec_map_t            map,
    output logic                          any,
    output logic [lipu_pkg::VIDX_W-1:0]   top
);
    import lipu_pkg::*;

    // binary tree: each node keeps "any set" and the highest set index below it
    logic [VIDX_W:0][TREE_SIZE-1:0]             any_tree;
    logic [VIDX_W:0][TREE_SIZE-1:0][VIDX_W-1:0] idx_tree;

    always_comb
    begin
        any_tree = '0;
        idx_tree = '0;
        for (int i = 0; i < NUM_VECTORS; i++)
        begin
            any_tree[0][i] = map[i];
        end
        for (int lvl = 1; lvl <= VIDX_W; lvl++)
        begin
            for (int n = 0; n < (TREE_SIZE >> lvl); n++)
            begin
                any_tree[lvl][n] = any_tree[lvl-1][2*n] | any_tree[lvl-1][2*n+1];
                if (any_tree[lvl-1][2*n+1])
                    idx_tree[lvl][n] = idx_tree[lvl-1][2*n+1] | (VIDX_W'(1) << (lvl - 1));
                else
                    idx_tree[lvl][n] = idx_tree[lvl-1][2*n];
            end
        end
    end

    assign any = any_tree[VIDX_W][0];
    assign top = idx_tree[VIDX_W][0];

endmodule

// File: design/lipu_vec_maps.sv
module lipu_vec_maps (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lipu_pkg::lipu_req_t    req,
    input  logic                   commit,
    input  logic                   unit_enabled,
    output lipu_pkg::lipu_exec_t   exec,
    output lipu_pkg::lipu_status_t status
);
    import lipu_pkg::*;

    vec_map_t          pend_reg, pend_next;
    vec_map_t          isr_reg,  isr_next;
    vec_map_t          lvl_reg,  lvl_next;
    logic [PRIO_W-1:0] tpr_reg,  tpr_next;

    logic              pend_any, isr_any;
    logic [VIDX_W-1:0] pend_top, isr_top;
    logic [VEC_W-1:0]  pend_top_vec, isr_top_vec;
    logic [PRIO_W-1:0] ppr_now;
    logic              dlv_ok;
    logic              post_in_range;
    logic [VIDX_W-1:0] post_idx;
    logic              was_pending;

    lipu_prio_enc u_pend_enc (
        .map (pend_reg),
        .any (pend_any),
        .top (pend_top)
    );

    lipu_prio_enc u_isr_enc (
        .map (isr_reg),
        .any (isr_any),
        .top (isr_top)
    );

    assign pend_top_vec = VEC_W'(pend_top);
    assign isr_top_vec  = VEC_W'(isr_top);

    // state as it stands: feeds this beat's operation and the previous beat's status
    assign ppr_now = calc_ppr(tpr_reg, isr_top_vec);
    assign dlv_ok  = is_deliverable(unit_enabled, pend_any, pend_top_vec, ppr_now);

    always_comb
    begin
        status.processor_priority = ppr_now;
        status.deliverable_valid  = dlv_ok;
        status.deliverable_vector = dlv_ok ? pend_top_vec : '0;
    end

    assign post_in_range = {1'b0, req.vector} < (VEC_W + 1)'(NUM_VECTORS);
    assign post_idx      = req.vector[VIDX_W-1:0];
    assign was_pending   = pend_reg[post_idx];

    always_comb
    begin
        pend_next = pend_reg;
        isr_next  = isr_reg;
        lvl_next  = lvl_reg;
        tpr_next  = tpr_reg;
        exec      = '0;
        case (req.func)
            FUNC_POST:
            begin
                if (unit_enabled && post_in_range)
                begin
                    pend_next[post_idx] = 1'b1;
                    // repeated level post is dropped
                    if (!(was_pending && req.level_trigger))
                    begin
                        lvl_next[post_idx] = req.level_trigger;
                        exec.accepted      = !was_pending;
                    end
                end
            end
            FUNC_ACK:
            begin
                if (dlv_ok)
                begin
                    isr_next[pend_top]    = 1'b1;
                    pend_next[pend_top]   = 1'b0;
                    exec.delivered_valid  = 1'b1;
                    exec.delivered_vector = pend_top_vec;
                end
            end
            FUNC_EOI:
            begin
                if (isr_any)
                begin
                    isr_next[isr_top]   = 1'b0;
                    lvl_next[isr_top]   = 1'b0;
                    exec.retired_valid  = 1'b1;
                    exec.retired_vector = isr_top_vec;
                    exec.level_notify   = lvl_reg[isr_top];
                end
            end
            FUNC_SET_TPR:
            begin
                tpr_next = req.task_priority;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            isr_reg  <= '0;
            lvl_reg  <= '0;
            tpr_reg  <= '0;
        end
        else if (commit)
        begin
            pend_reg <= pend_next;
            isr_reg  <= isr_next;
            lvl_reg  <= lvl_next;
            tpr_reg  <= tpr_next;
        end
    end

endmodule

// File: design/local_interrupt_priority_unit_top.sv
// Channel | Role  | Beat carries
// --------+-------+--------------------------------------------------------------
// req     | sink  | func, vector, level_trigger, task_priority
// rsp     | source| accepted, delivered/retired/deliverable results, processor_priority
// cfg     | sink  | unit_enabled (always ready)
//
// One beat per cycle sustained while rsp is ready; a req beat passes the s0, s1
// and output registers to become an rsp beat. Pending/in-service priority encoders
// feed the operation; maps commit as a beat leaves s0; status is read as it exits s1.
// Reset clears the three 256-bit maps, task priority and enable at once (no sweep).
// A stalled rsp holds the pipe: maps change only when a beat moves past stage one.

`include "local_interrupt_priority_unit_top_defines.svh"

module local_interrupt_priority_unit_top (
    input  logic       clk,
    input  logic       rst_n,
    lipu_req_if.sink   req,
    lipu_rsp_if.source rsp,
    lipu_cfg_if.sink   cfg
);
    import lipu_pkg::*;

    logic         unit_enabled_reg;

    logic         s0_valid_reg, s0_valid_next;
    lipu_req_t    s0_req_reg;
    logic         s1_valid_reg, s1_valid_next;
    lipu_exec_t   s1_exec_reg;
    logic         out_valid_reg, out_valid_next;
    lipu_rsp_t    out_rsp_reg;

    logic         out_adv;
    logic         s1_load;
    logic         s0_load;
    logic         commit;
    lipu_req_t    req_beat;
    lipu_exec_t   exec;
    lipu_status_t status;

    assign out_adv = !out_valid_reg || rsp.ready;
    assign s1_load = !s1_valid_reg || out_adv;
    assign s0_load = !s0_valid_reg || s1_load;
    assign commit  = s0_valid_reg && s1_load;

    assign req.ready = s0_load;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        req_beat.func          = func_t'(req.func);
        req_beat.vector        = req.vector;
        req_beat.level_trigger = req.level_trigger;
        req_beat.task_priority = req.task_priority;
    end

    lipu_vec_maps u_maps (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (s0_req_reg),
        .commit       (commit),
        .unit_enabled (unit_enabled_reg),
        .exec         (exec),
        .status       (status)
    );

    assign s0_valid_next  = s0_load ? req.valid : s0_valid_reg;
    assign s1_valid_next  = s1_load ? s0_valid_reg : s1_valid_reg;
    assign out_valid_next = out_adv ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            unit_enabled_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.ready)
                unit_enabled_reg <= cfg.unit_enabled;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s0_load && req.valid)
            s0_req_reg <= req_beat;
        if (commit)
            s1_exec_reg <= exec;
        // status seen here reflects the maps just after the stage-one beat committed
        if (out_adv && s1_valid_reg)
        begin
            out_rsp_reg.exec   <= s1_exec_reg;
            out_rsp_reg.status <= status;
        end
    end

    assign rsp.valid              = out_valid_reg;
    assign rsp.accepted           = out_rsp_reg.exec.accepted;
    assign rsp.delivered_valid    = out_rsp_reg.exec.delivered_valid;
    assign rsp.delivered_vector   = out_rsp_reg.exec.delivered_vector;
    assign rsp.retired_valid      = out_rsp_reg.exec.retired_valid;
    assign rsp.level_notify       = out_rsp_reg.exec.level_notify;
    assign rsp.retired_vector     = out_rsp_reg.exec.retired_vector;
    assign rsp.processor_priority = out_rsp_reg.status.processor_priority;
    assign rsp.deliverable_valid  = out_rsp_reg.status.deliverable_valid;
    assign rsp.deliverable_vector = out_rsp_reg.status.deliverable_vector;

    `LIPU_ASSERT_IMP(a_dlv_above_ppr, rsp.valid && rsp.deliverable_valid, (rsp.deliverable_vector & CLASS_MASK) > rsp.processor_priority, "deliverable vector not above processor priority")
    `LIPU_ASSERT_IMP(a_ack_raises_ppr, rsp.valid && rsp.delivered_valid, rsp.processor_priority >= (rsp.delivered_vector & CLASS_MASK), "processor priority below delivered class")
    `LIPU_ASSERT_IMP(a_notify_needs_retire, rsp.valid && rsp.level_notify, rsp.retired_valid && !rsp.delivered_valid, "level notify without retire")
    `LIPU_ASSERT_NXT(a_cfg_write, cfg.valid && cfg.ready, unit_enabled_reg == $past(cfg.unit_enabled), "enable write lost")

endmodule
